@@ rtl/core/apfd_pkg.sv @@
// ---------------------------------------------------------------------------
// Pulse frame decoder package
// Shared types and constants for the tri-state remote pulse frame decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package apfd_pkg;

	// Number of code bits in one frame, and the pulses that make up a frame.
	localparam int unsigned CODE_BITS    = 12;
	localparam int unsigned GROUP_PULSES = 4 * CODE_BITS;
	localparam int unsigned FRAME_PULSES = GROUP_PULSES + 2;
	localparam int unsigned COUNT_W      = 6;

	localparam logic [COUNT_W-1:0] COUNT_MAX        = 6'd63;
	localparam logic [COUNT_W-1:0] COUNT_GROUP_LAST = COUNT_W'(GROUP_PULSES);
	localparam logic [COUNT_W-1:0] COUNT_FRAME      = COUNT_W'(FRAME_PULSES);
	localparam logic [COUNT_W-1:0] COUNT_WIDTH_LAST = COUNT_W'(GROUP_PULSES + 1);

	// Reset values.
	localparam logic [7:0] WIDTH_INIT      = 8'd22;
	localparam logic [7:0] BIT_THR_INIT    = 8'd23;
	localparam logic [7:0] IMP_THR_INIT    = 8'd12;

	// Frame tags that arrive with the first pulse.
	localparam logic [7:0] TAG_SKIP    = 8'd15;
	localparam logic [7:0] TAG_REJECT  = 8'd63;
	localparam logic [7:0] TAG_IMPULSE = 8'd33;

	// Group patterns, first pulse in the highest bit (L = 1, S = 0).
	localparam logic [3:0] PAT_SLSL = 4'b0101;
	localparam logic [3:0] PAT_SLSS = 4'b0100;
	localparam logic [3:0] PAT_SLLS = 4'b0110;
	localparam logic [3:0] PAT_LSLS = 4'b1010;
	localparam logic [3:0] PAT_LLSL = 4'b1101;

	// Button table codes of the button layout.
	localparam logic [4:0] BTN_1 = 5'h1E;
	localparam logic [4:0] BTN_2 = 5'h1D;
	localparam logic [4:0] BTN_3 = 5'h1B;
	localparam logic [4:0] BTN_4 = 5'h17;
	localparam logic [4:0] BTN_5 = 5'h0F;

	localparam logic [6:0] ASCII_A = 7'h41;

	// Fixed bits that the ARC layout requires to be set.
	localparam logic [CODE_BITS-1:0] ARC_FIXED_MASK = 12'h600;

	// Configuration register indexes.
	typedef enum logic {
		REG_BIT_THRESHOLD   = 1'b0,
		REG_IMPULSE_FIRST   = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_DECODED  = 2'd0,
		ST_REJECTED = 2'd1,
		ST_SKIPPED  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FAM_ARC     = 2'd0,
		FAM_BUTTON  = 2'd1,
		FAM_IMPULSE = 2'd2
	} family_t;

	// Timing classes found from the shortest and longest pulse widths.
	typedef enum logic [2:0] {
		TM_NONE    = 3'd0,
		TM_ONE     = 3'd1,
		TM_TWO     = 3'd2,
		TM_THREE   = 3'd3,
		TM_BUTTON  = 3'd4,
		TM_IMPULSE = 3'd5
	} timing_t;

	typedef struct packed {
		logic rej;
		logic skip;
		logic imp;
		logic err;
		logic open;
	} frame_flags_t;

	// One result item, first field in the highest bits.
	typedef struct packed {
		logic [CODE_BITS-1:0] raw_code;
		logic                 switch_on;
		logic [5:0]           unit_number;
		logic [6:0]           house_letter;
		family_t              device_family;
		status_t              status;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/core/arc_pulse_frame_decoder.sv @@
// Path: a pulse passes the input register, then the frame update logic; the
// result of a frame end is held in the output register for the master side.
// Throughput: one pulse per cycle, set by the single frame update stage; a
// frame end waits only while an earlier result has not yet left.
// Reset: arst_n clears the open frame, both stages and the thresholds
// (23 and 12) at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
// Pulse frame decoder
// Turns a stream of pulse widths into one decoded remote frame result.
// ---------------------------------------------------------------------------
`default_nettype none

module arc_pulse_frame_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Slave side: tdata = pulse_width; tuser = frame_start, frame_tag[7:0];
	// tlast = frame_end.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,
	input  wire logic [8:0]  s_tuser,
	input  wire logic        s_tlast,
	// Master side: tdata = status[1:0], device_family[1:0], house_letter[6:0],
	// unit_number[5:0], switch_on, raw_code[11:0], two zero bits.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,
	// Configuration write port.
	input  wire logic        cfg_wen,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_wdata
);

	localparam int unsigned CB = apfd_pkg::CODE_BITS;

	// Configuration registers.
	logic [7:0] bit_thr_q;
	logic [7:0] imp_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_thr_q <= apfd_pkg::BIT_THR_INIT;
			imp_thr_q <= apfd_pkg::IMP_THR_INIT;
		end else if (cfg_wen) begin
			unique case (apfd_pkg::cfg_reg_t'(cfg_index))
				apfd_pkg::REG_BIT_THRESHOLD: bit_thr_q <= cfg_wdata;
				apfd_pkg::REG_IMPULSE_FIRST: imp_thr_q <= cfg_wdata;
				default:                     bit_thr_q <= bit_thr_q;
			endcase
		end
	end

	// Input register stage.
	logic        vld_s1;
	logic [7:0]  pw_s1;
	logic        start_s1;
	logic        end_s1;
	logic [7:0]  tag_s1;
	logic        adv_s1;

	// Output register.
	logic                 out_vld_q;
	apfd_pkg::result_t    out_q;

	// Frame state.
	logic [apfd_pkg::COUNT_W-1:0] cnt_q;
	logic [CB-1:0]                code_q;
	logic [2:0]                   marks_q;
	logic [7:0]                   lo_q;
	logic [7:0]                   hi_q;
	apfd_pkg::frame_flags_t       flags_q;

	// Next frame state and the result of the frame end.
	logic [apfd_pkg::COUNT_W-1:0] cnt_d;
	logic [CB-1:0]                code_d;
	logic [2:0]                   marks_d;
	logic [7:0]                   lo_d;
	logic [7:0]                   hi_d;
	apfd_pkg::frame_flags_t       flags_d;
	logic                         res_vld;
	apfd_pkg::result_t            res;

	// The stage moves on unless it holds a result that cannot leave yet.
	assign adv_s1   = vld_s1 && !(res_vld && out_vld_q && !m_tready);
	assign s_tready = !vld_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pw_s1    <= s_tdata;
			start_s1 <= s_tuser[0];
			tag_s1   <= s_tuser[8:1];
			end_s1   <= s_tlast;
		end
	end

	// Frame update and end of frame decoding.
	always_comb begin
		logic [apfd_pkg::COUNT_W-1:0] cm1;
		logic [3:0]                   grp;
		logic [7:0]                   thr;
		logic                         lng;
		logic [3:0]                   pat;
		logic                         bit_zero;
		logic                         bit_one;
		apfd_pkg::timing_t            tm;
		logic [4:0]                   btn;
		logic [CB-1:0]                b;

		cnt_d    = cnt_q;
		code_d   = code_q;
		marks_d  = marks_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		flags_d  = flags_q;
		res_vld  = 1'b0;
		res      = '0;
		cm1      = '0;
		grp      = '0;
		thr      = bit_thr_q;
		lng      = 1'b0;
		pat      = '0;
		bit_zero = 1'b0;
		bit_one  = 1'b0;
		tm       = apfd_pkg::TM_NONE;
		btn      = '0;
		b        = '0;

		// A start pulse opens a fresh frame and takes its tag.
		if (start_s1) begin
			cnt_d        = '0;
			code_d       = '0;
			marks_d      = '0;
			lo_d         = apfd_pkg::WIDTH_INIT;
			hi_d         = apfd_pkg::WIDTH_INIT;
			flags_d      = '0;
			flags_d.open = 1'b1;
			if (tag_s1 == apfd_pkg::TAG_SKIP)
				flags_d.skip = 1'b1;
			else if (tag_s1 == apfd_pkg::TAG_REJECT)
				flags_d.rej = 1'b1;
			else if (tag_s1 == apfd_pkg::TAG_IMPULSE)
				flags_d.imp = 1'b1;
		end

		if (flags_d.open) begin
			if (cnt_d < apfd_pkg::COUNT_MAX)
				cnt_d = cnt_d + 1'b1;

			// Short/long mark of one pulse of a code group.
			if (cnt_d <= apfd_pkg::COUNT_GROUP_LAST) begin
				cm1 = cnt_d - 1'b1;
				grp = cm1[5:2];
				thr = (grp == 4'd0 && flags_d.imp) ? imp_thr_q : bit_thr_q;
				lng = (pw_s1 > thr);
				if (pw_s1 == thr)
					flags_d.err = 1'b1;
				if (cm1[1:0] != 2'd3) begin
					marks_d = {marks_d[1:0], lng};
				end else begin
					// Fourth pulse: the group becomes one code bit.
					pat = {marks_d, lng};
					if (pat == apfd_pkg::PAT_SLSL || pat == apfd_pkg::PAT_SLSS)
						bit_zero = 1'b1;
					else if (pat == apfd_pkg::PAT_SLLS)
						bit_one = 1'b1;
					else if (pat == apfd_pkg::PAT_LSLS && flags_d.imp)
						bit_zero = 1'b1;
					else if (pat == apfd_pkg::PAT_LLSL && grp == 4'd0)
						bit_zero = 1'b1;
					if (bit_zero)
						code_d = {1'b0, code_d[CB-1:1]};
					else if (bit_one)
						code_d = {1'b1, code_d[CB-1:1]};
					else
						flags_d.err = 1'b1;
					marks_d = '0;
				end
			end

			// Shortest and longest widths over the inner pulses.
			if (cnt_d >= 6'd2 && cnt_d <= apfd_pkg::COUNT_WIDTH_LAST) begin
				if (pw_s1 < lo_d)
					lo_d = pw_s1;
				else if (pw_s1 > hi_d)
					hi_d = pw_s1;
			end

			if (end_s1) begin
				res_vld = 1'b1;
				b       = code_d;
				tm      = flags_d.imp ? apfd_pkg::TM_IMPULSE : apfd_pkg::TM_NONE;
				btn     = b[9:5];

				// Timing class. The first button window is empty and never matches.
				if ((lo_d == 8'd9 || lo_d == 8'd10) &&
				    (hi_d == 8'd36 || hi_d == 8'd37 || (hi_d >= 8'd40 && hi_d <= 8'd42)))
					tm = apfd_pkg::TM_ONE;
				else if ((lo_d == 8'd10 || lo_d == 8'd11) && hi_d >= 8'd40 && hi_d <= 8'd42)
					tm = apfd_pkg::TM_TWO;
				else if (lo_d == 8'd13 && hi_d >= 8'd32 && hi_d <= 8'd34)
					tm = apfd_pkg::TM_THREE;
				else if (lo_d >= 8'd125 && lo_d <= 8'd12 && hi_d >= 8'd31 && hi_d <= 8'd37)
					tm = apfd_pkg::TM_BUTTON;
				else if ((lo_d == 8'd12 || lo_d == 8'd13) && (hi_d == 8'd45 || hi_d == 8'd46))
					tm = apfd_pkg::TM_BUTTON;

				priority if (cnt_d != apfd_pkg::COUNT_FRAME) begin
					res.status = apfd_pkg::ST_REJECTED;
				end else if (flags_d.skip) begin
					res.status = apfd_pkg::ST_SKIPPED;
				end else if (flags_d.rej || flags_d.err) begin
					res.status = apfd_pkg::ST_REJECTED;
				end else if (tm == apfd_pkg::TM_BUTTON) begin
					// Button layout; an unknown button falls back to the ARC family.
					res.raw_code      = b;
					res.house_letter  = {2'b00, ~b[4:0]} + apfd_pkg::ASCII_A;
					res.device_family = apfd_pkg::FAM_BUTTON;
					res.switch_on     = (b[11:10] == 2'd2);
					if (btn == apfd_pkg::BTN_1)
						res.unit_number = 6'd1;
					else if (btn == apfd_pkg::BTN_2)
						res.unit_number = 6'd2;
					else if (btn == apfd_pkg::BTN_3)
						res.unit_number = 6'd3;
					else if (btn == apfd_pkg::BTN_4)
						res.unit_number = 6'd4;
					else if (btn == apfd_pkg::BTN_5)
						res.unit_number = 6'd5;
					else begin
						res.unit_number   = {1'b0, btn};
						res.device_family = apfd_pkg::FAM_ARC;
						res.switch_on     = 1'b0;
					end
				end else if (tm == apfd_pkg::TM_IMPULSE) begin
					res.raw_code      = b;
					res.device_family = apfd_pkg::FAM_IMPULSE;
					res.house_letter  = {3'b000, ~b[3:0]} + apfd_pkg::ASCII_A;
					res.unit_number   = {1'b0, ~b[8:4]};
					res.switch_on     = (b[11:10] == 2'd1);
				end else if ((b & apfd_pkg::ARC_FIXED_MASK) != apfd_pkg::ARC_FIXED_MASK) begin
					res.status = apfd_pkg::ST_REJECTED;
				end else begin
					res.raw_code      = b;
					res.device_family = apfd_pkg::FAM_ARC;
					res.house_letter  = {3'b000, b[3:0]} + apfd_pkg::ASCII_A;
					res.unit_number   = {2'b00, b[7:4]} + 6'd1;
					res.switch_on     = b[11];
				end

				// The frame closes after its result.
				cnt_d   = '0;
				code_d  = '0;
				marks_d = '0;
				lo_d    = apfd_pkg::WIDTH_INIT;
				hi_d    = apfd_pkg::WIDTH_INIT;
				flags_d = '0;
			end
		end
	end

	// Frame state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			code_q  <= '0;
			marks_q <= '0;
			lo_q    <= apfd_pkg::WIDTH_INIT;
			hi_q    <= apfd_pkg::WIDTH_INIT;
			flags_q <= '0;
		end else if (adv_s1) begin
			cnt_q   <= cnt_d;
			code_q  <= code_d;
			marks_q <= marks_d;
			lo_q    <= lo_d;
			hi_q    <= hi_d;
			flags_q <= flags_d;
		end
	end

	// Result register; a waiting result holds until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1 && res_vld) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_vld)
			out_q <= res;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, out_q};

endmodule

`default_nettype wire
